FILE: design/assert_macros.svh
// Assertion macros shared by the zone bitmap allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ZBA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked on every edge, reset included.
`define ZBA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/zba_pkg.sv
// Package with types, codes and defaults for the zone bitmap allocator.
package zba_pkg;

  // Fixed field widths.
  localparam int ZONE_W       = 16;
  localparam int STATUS_W     = 3;
  localparam int MAP_BLOCKS_W = 4;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  // Default sizing of the bitmap.
  localparam int DEF_BITS_PER_MAP_BLOCK = 8192;
  localparam int DEF_MAX_MAP_BLOCKS     = 8;
  localparam int DEF_WORD_BITS          = 32;

  // Request codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE      = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RANGE = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_BLOCK_ABSENT = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_ALREADY_FREE = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_DATA_ZONE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZONE_COUNT      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_BLOCKS      = 2'd2;

  // Request transaction payload.
  typedef struct packed {
    logic              func;
    logic [ZONE_W-1:0] free_zone;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [ZONE_W-1:0]   zone;
    logic [STATUS_W-1:0] status;
  } out_item_t;

endpackage

FILE: design/zba_bitmap_ram.sv
// Single write, single read bitmap memory with a registered read port.
module zba_bitmap_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered: data is valid in the cycle after the address.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/zba_word_unit.sv
// Shared word unit: full test, first clear bit search and bit set or clear.
module zba_word_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic [WORD_BITS-1:0]         word,
  input  logic [$clog2(WORD_BITS)-1:0] bit_idx,
  output logic                         all_ones,
  output logic [$clog2(WORD_BITS)-1:0] first_zero,
  output logic [WORD_BITS-1:0]         set_word,
  output logic [WORD_BITS-1:0]         clr_word,
  output logic                         bit_val
);

  localparam int BIT_W = $clog2(WORD_BITS);

  // A word with no clear bit is skipped by the scan.
  assign all_ones = &word;

  // Lowest clear bit; scanning downward lets the lowest one win.
  always_comb begin
    first_zero = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        first_zero = BIT_W'(i);
      end
    end
  end

  // Word with the found bit marked as used.
  assign set_word = word | (WORD_BITS'(1) << first_zero);

  // Word with the addressed bit released, and that bit's old value.
  assign clr_word = word & ~(WORD_BITS'(1) << bit_idx);
  assign bit_val  = word[bit_idx];

endmodule

FILE: design/zone_bitmap_allocator_unit.sv
// Zone bitmap allocator top level: configuration, sequencer and result register.
// After reset the block sweeps the whole bitmap memory to zero, one word per
// cycle, and takes no request until the sweep ends; configuration writes are
// taken throughout. Requests are handled one at a time. A free reads its word
// on acceptance, then checks and releases the bit (S_FCHK) and passes the
// outcome on through S_RESP; a free refused by the range or block checks, and
// an allocate with no block present, go straight to S_RESP. An allocate streams
// the bitmap memory through its single read port one word per cycle, checking
// each word while the next read is in flight, and stops at the first word with
// a clear bit (then S_AFIN and S_RESP) or, when no present word has a clear
// bit, after the last present word. A finished result is held in an output
// register, and the next request is accepted while it waits.
// BITS_PER_MAP_BLOCK and WORD_BITS must be powers of two.
`include "assert_macros.svh"

module zone_bitmap_allocator_unit #(
  parameter int BITS_PER_MAP_BLOCK = zba_pkg::DEF_BITS_PER_MAP_BLOCK,
  parameter int MAX_MAP_BLOCKS     = zba_pkg::DEF_MAX_MAP_BLOCKS,
  parameter int WORD_BITS          = zba_pkg::DEF_WORD_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  zba_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output zba_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [zba_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [zba_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import zba_pkg::*;

  localparam int WPB         = BITS_PER_MAP_BLOCK / WORD_BITS;
  localparam int WPB_LOG     = $clog2(WPB);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int BLK_LOG     = $clog2(BITS_PER_MAP_BLOCK);
  localparam int TOTAL_WORDS = MAX_MAP_BLOCKS * WPB;
  localparam int AW          = $clog2(TOTAL_WORDS);
  localparam int CNT_W       = AW + 1;
  localparam int POS_W       = AW + BIT_W;
  localparam int OFF_W       = ZONE_W + 1;
  localparam int SUM_W       = POS_W + ZONE_W + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_AFIN,
    S_FCHK,
    S_RESP
  } state_t;

  state_t state;

  // Configuration registers.
  logic [ZONE_W-1:0]       first_data_zone;
  logic [ZONE_W-1:0]       zone_count;
  logic [MAP_BLOCKS_W-1:0] map_blocks;

  // Sequencer registers.
  logic [AW-1:0]    clr_addr;
  logic [CNT_W-1:0] issue_cnt;
  logic [CNT_W-1:0] scan_words;
  logic             chk_valid;
  logic [AW-1:0]    chk_addr;
  logic [POS_W-1:0] pos;
  logic [AW-1:0]    f_addr;
  logic [BIT_W-1:0] f_bit;
  out_item_t        res;

  // Memory and word unit connections.
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;
  logic                 wu_all_ones;
  logic [BIT_W-1:0]     wu_first_zero;
  logic [WORD_BITS-1:0] wu_set_word;
  logic [WORD_BITS-1:0] wu_clr_word;
  logic                 wu_bit_val;

  // Request decode.
  logic                    in_fire;
  logic [MAP_BLOCKS_W-1:0] nb;
  logic                    free_in_range;
  logic [OFF_W-1:0]        free_off;
  logic                    free_blk_ok;
  logic [SUM_W-1:0]        pos_sum;
  logic                    pos_bad;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_data_zone <= ZONE_W'(1);
      zone_count      <= '0;
      map_blocks      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_DATA_ZONE: first_data_zone <= cfg_data[ZONE_W-1:0];
        CFG_ZONE_COUNT:      zone_count      <= cfg_data[ZONE_W-1:0];
        CFG_MAP_BLOCKS:      map_blocks      <= cfg_data[MAP_BLOCKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Present blocks, limited to the bitmap's capacity.
  assign nb = (5'(map_blocks) > 5'(MAX_MAP_BLOCKS)) ? MAP_BLOCKS_W'(MAX_MAP_BLOCKS)
                                                    : map_blocks;

  // Free request checks; the offset counts from one below the first data zone.
  assign free_in_range = (in_item.free_zone >= first_data_zone) &&
                         (in_item.free_zone < zone_count);
  assign free_off      = OFF_W'(in_item.free_zone) - OFF_W'(first_data_zone) + OFF_W'(1);
  assign free_blk_ok   = (free_off >> BLK_LOG) < OFF_W'(nb);

  // Zone check for an allocated bit position.
  assign pos_sum = SUM_W'(pos) + SUM_W'(first_data_zone);
  assign pos_bad = (pos == '0) || (pos_sum >= SUM_W'(zone_count) + SUM_W'(1));

  // Memory read address: the scan stream, or the word of a free request.
  always_comb begin
    if (state == S_SCAN) begin
      mem_re    = issue_cnt < scan_words;
      mem_raddr = AW'(issue_cnt);
    end else begin
      mem_re    = in_fire;
      mem_raddr = AW'(free_off >> BIT_W);
    end
  end

  // Memory write: clearing sweep, set of a found bit, or release of a bit.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_SCAN: begin
        mem_we    = chk_valid && !wu_all_ones;
        mem_waddr = chk_addr;
        mem_wdata = wu_set_word;
      end
      S_FCHK: begin
        mem_we    = 1'b1;
        mem_waddr = f_addr;
        mem_wdata = wu_clr_word;
      end
      default: ;
    endcase
  end

  zba_bitmap_ram #(
    .DEPTH (TOTAL_WORDS),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  zba_word_unit #(
    .WORD_BITS (WORD_BITS)
  ) u_word (
    .word       (mem_rdata),
    .bit_idx    (f_bit),
    .all_ones   (wu_all_ones),
    .first_zero (wu_first_zero),
    .set_word   (wu_set_word),
    .clr_word   (wu_clr_word),
    .bit_val    (wu_bit_val)
  );

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // A taken result empties the register unless a new one replaces it.
      if (out_valid && out_ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(TOTAL_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            res.zone  <= '0;
            chk_valid <= 1'b0;
            if (in_item.func == FUNC_ALLOC) begin
              if (nb == '0) begin
                res.status <= STATUS_NO_FREE;
                state      <= S_RESP;
              end else begin
                issue_cnt  <= '0;
                scan_words <= CNT_W'(nb) << WPB_LOG;
                state      <= S_SCAN;
              end
            end else if (!free_in_range) begin
              res.status <= STATUS_OUT_OF_RANGE;
              state      <= S_RESP;
            end else if (!free_blk_ok) begin
              res.status <= STATUS_BLOCK_ABSENT;
              state      <= S_RESP;
            end else begin
              f_addr <= AW'(free_off >> BIT_W);
              f_bit  <= free_off[BIT_W-1:0];
              state  <= S_FCHK;
            end
          end
        end
        S_SCAN: begin
          // Keep one read in flight while the previous word is checked.
          if (issue_cnt < scan_words) begin
            issue_cnt <= issue_cnt + CNT_W'(1);
            chk_valid <= 1'b1;
            chk_addr  <= AW'(issue_cnt);
          end else begin
            chk_valid <= 1'b0;
          end
          if (chk_valid) begin
            if (!wu_all_ones) begin
              pos   <= {chk_addr, wu_first_zero};
              state <= S_AFIN;
            end else if (CNT_W'(chk_addr) == scan_words - CNT_W'(1)) begin
              res.status <= STATUS_NO_FREE;
              state      <= S_RESP;
            end
          end
        end
        S_AFIN: begin
          if (pos_bad) begin
            res.status <= STATUS_OUT_OF_RANGE;
          end else begin
            res.zone   <= ZONE_W'(pos_sum - SUM_W'(1));
            res.status <= STATUS_OK;
          end
          state <= S_RESP;
        end
        S_FCHK: begin
          res.status <= wu_bit_val ? STATUS_OK : STATUS_ALREADY_FREE;
          state      <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_item  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // One request at a time: the block is busy right after an acceptance.
  `ZBA_ASSERT(a_one_at_a_time, clk, rst, (in_valid && in_ready) |=> !in_ready,
              "request accepted while the previous one is still in progress")

  // The bitmap is only written by the sweep, a found bit or a released bit.
  `ZBA_ASSERT(a_write_states, clk, rst, mem_we |-> (state != S_IDLE && state != S_RESP),
              "bitmap written outside a working state")

  // A checked word always lies among the present blocks.
  `ZBA_ASSERT(a_scan_bound, clk, rst,
              (state == S_SCAN && chk_valid) |-> (CNT_W'(chk_addr) < scan_words),
              "scan checked a word beyond the present blocks")

endmodule

FILE: tb/sv/zone_bitmap_allocator_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the zone bitmap allocator: directed and random transactions.
module zone_bitmap_allocator_unit_test;
  import zba_pkg::*;

  localparam int WORDS_PER_BLOCK = DEF_BITS_PER_MAP_BLOCK / DEF_WORD_BITS;
  localparam int MAP_WORDS = DEF_MAX_MAP_BLOCKS * WORDS_PER_BLOCK;
  localparam int BLOCK_SHIFT = $clog2(DEF_BITS_PER_MAP_BLOCK);
  localparam int IDLE_LIMIT = 10000;
  localparam int LONG_HOLD = 400;
  localparam int ITEMS_PER_SEGMENT = 42;
  localparam int SEGMENTS = 6;
  localparam int FILL_ITEMS = 16;
  localparam int DRAIN_CYCLES = 2100;

  // Scoreboard: keeps its own copy of the bitmap and registers, and queues the
  // outcome of every accepted request until the block returns it.
  class zone_map_scoreboard;
    logic [DEF_WORD_BITS-1:0] map_words [MAP_WORDS];
    int unsigned first_zone;
    int unsigned zone_total;
    int unsigned block_setting;
    out_item_t pending_outcomes [$];
    out_item_t last_outcome;
    int errors;

    function new();
      foreach (map_words[i]) map_words[i] = '0;
      first_zone = 1;
      zone_total = 0;
      block_setting = 0;
      errors = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_FIRST_DATA_ZONE: first_zone = 32'(value);
        CFG_ZONE_COUNT: zone_total = 32'(value);
        CFG_MAP_BLOCKS: block_setting = 32'(value[MAP_BLOCKS_W-1:0]);
        default: ;
      endcase
    endfunction

    // Applies one request to the bitmap and returns the outcome the block owes.
    function out_item_t allocate_or_free(in_item_t req);
      out_item_t res;
      int unsigned blocks;
      int unsigned pos;
      int unsigned off;
      int unsigned w;
      int unsigned b;
      res.zone = '0;
      res.status = STATUS_OK;
      blocks = (block_setting > DEF_MAX_MAP_BLOCKS) ? DEF_MAX_MAP_BLOCKS : block_setting;
      if (req.func == FUNC_ALLOC) begin
        // The first word with a clear bit holds the lowest free zone.
        res.status = STATUS_NO_FREE;
        for (w = 0; w < blocks * WORDS_PER_BLOCK; w++) begin
          if (!(&map_words[w])) begin
            for (b = 0; b < DEF_WORD_BITS; b++) begin
              if (!map_words[w][b]) break;
            end
            map_words[w][b] = 1'b1;
            pos = w * DEF_WORD_BITS + b;
            if (pos == 0 || pos + first_zone >= zone_total + 1) begin
              res.status = STATUS_OUT_OF_RANGE;
            end else begin
              res.status = STATUS_OK;
              res.zone = ZONE_W'(pos + first_zone - 1);
            end
            break;
          end
        end
      end else if (32'(req.free_zone) < first_zone || 32'(req.free_zone) >= zone_total) begin
        res.status = STATUS_OUT_OF_RANGE;
      end else begin
        off = 32'(req.free_zone) - first_zone + 1;
        if ((off >> BLOCK_SHIFT) >= blocks) begin
          res.status = STATUS_BLOCK_ABSENT;
        end else begin
          w = off / DEF_WORD_BITS;
          b = off % DEF_WORD_BITS;
          if (!map_words[w][b]) res.status = STATUS_ALREADY_FREE;
          map_words[w][b] = 1'b0;
        end
      end
      return res;
    endfunction

    function void note_request(in_item_t req);
      last_outcome = allocate_or_free(req);
      pending_outcomes.push_back(last_outcome);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_outcomes.size() == 0) begin
        $error("result with no request waiting: zone %0d status %0d", got.zone, got.status);
        errors++;
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.zone !== want.zone) begin
        $error("zone: expected %0d, got %0d", want.zone, got.zone);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_item;
  logic out_valid;
  logic out_ready;
  out_item_t out_item;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  zone_map_scoreboard sb = new();
  bit burst = 1'b0;
  int hold_after = -1;
  int results_seen = 0;
  int idle_cycles = 0;
  logic [ZONE_W-1:0] live_zones [$];

  zone_bitmap_allocator_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Watchdog: ends the run once nothing has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls before each transaction, one long hold-off.
  initial begin : result_sink
    int hold;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      hold = burst ? 0 : $urandom_range(0, 19);
      if (results_seen == hold_after) hold = LONG_HOLD;
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_item);
      results_seen++;
    end
  end

  // Offers one request after a random gap and waits until it is taken.
  task automatic send_request(logic f_code, logic [ZONE_W-1:0] zone_arg);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{func: f_code, free_zone: zone_arg};
    do @(posedge clk); while (!in_ready);
    sb.note_request(in_item);
  endtask

  // Waits until every outcome is back, then writes all three registers.
  task automatic settle_and_configure(logic [CFG_DATA_W-1:0] fdz, logic [CFG_DATA_W-1:0] zc,
                                      logic [MAP_BLOCKS_W-1:0] mb);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FIRST_DATA_ZONE;
    cfg_data <= fdz;
    sb.set_register(CFG_FIRST_DATA_ZONE, fdz);
    @(negedge clk);
    cfg_index <= CFG_ZONE_COUNT;
    cfg_data <= zc;
    sb.set_register(CFG_ZONE_COUNT, zc);
    @(negedge clk);
    cfg_index <= CFG_MAP_BLOCKS;
    cfg_data <= CFG_DATA_W'(mb);
    sb.set_register(CFG_MAP_BLOCKS, CFG_DATA_W'(mb));
    @(negedge clk);
    cfg_we <= 1'b0;
    live_zones.delete();
  endtask

  initial begin : stimulus
    int seg;
    int n;
    int pick;
    int idx;
    logic [ZONE_W-1:0] target;
    logic [ZONE_W-1:0] last_freed;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_FIRST_DATA_ZONE;
    cfg_data = '0;
    last_freed = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: no blocks present and no valid zones.
    send_request(FUNC_ALLOC, 16'hFFFF);
    send_request(FUNC_FREE, 16'd5);

    // Map block count above the maximum; first allocation hits bit zero.
    settle_and_configure(16'd1, 16'd100, 4'd15);
    send_request(FUNC_ALLOC, 16'd0);
    send_request(FUNC_ALLOC, 16'hA5A5);
    send_request(FUNC_ALLOC, 16'h5A5A);
    send_request(FUNC_FREE, 16'd2);
    send_request(FUNC_FREE, 16'd2);
    send_request(FUNC_FREE, 16'd0);
    send_request(FUNC_FREE, 16'd100);
    send_request(FUNC_FREE, 16'd99);
    send_request(FUNC_ALLOC, 16'd0);

    // First data zone of zero, with frees landing in absent blocks.
    settle_and_configure(16'd0, 16'hFFFF, 4'd1);
    send_request(FUNC_FREE, 16'd8191);
    send_request(FUNC_FREE, 16'hFFFE);
    send_request(FUNC_FREE, 16'hFFFF);
    send_request(FUNC_ALLOC, 16'hFFFF);
    send_request(FUNC_FREE, 16'd0);

    // Top first data zone: every zone is out of range.
    settle_and_configure(16'hFFFF, 16'hFFFF, 4'd8);
    send_request(FUNC_ALLOC, 16'd0);
    send_request(FUNC_FREE, 16'hFFFE);
    send_request(FUNC_FREE, 16'hFFFF);

    // Back to back allocations in block 0.
    settle_and_configure(16'd1, 16'hFFFF, 4'd1);
    burst = 1'b1;
    repeat (FILL_ITEMS) send_request(FUNC_ALLOC, 16'($urandom));
    burst = 1'b0;

    // Bits of a block that is hidden and shown again are kept.
    settle_and_configure(16'd1, 16'hFFFF, 4'd1);
    send_request(FUNC_ALLOC, 16'd0);
    settle_and_configure(16'd1, 16'hFFFF, 4'd0);
    send_request(FUNC_ALLOC, 16'd0);
    send_request(FUNC_FREE, 16'd1);
    settle_and_configure(16'd1, 16'hFFFF, 4'd1);
    send_request(FUNC_ALLOC, 16'd0);
    send_request(FUNC_FREE, 16'd1);

    // Random segments: mostly allocate then free what came back, plus noise.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: settle_and_configure(16'd1, 16'hFFFF, 4'd8);
        1: settle_and_configure(16'($urandom_range(1, 300)), 16'($urandom_range(8200, 65535)),
                                4'($urandom_range(2, 8)));
        2: settle_and_configure(16'd0, 16'hFFFF, 4'd15);
        3: settle_and_configure(16'($urandom), 16'($urandom), 4'($urandom_range(0, 15)));
        4: settle_and_configure(16'($urandom_range(1, 40)), 16'($urandom_range(50, 9000)), 4'd1);
        default: settle_and_configure(16'd1, 16'hFFFF, 4'd3);
      endcase
      burst = (seg == 2);
      if (seg == 0) hold_after = results_seen + 20;
      for (n = 0; n < ITEMS_PER_SEGMENT; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35 && live_zones.size() != 0) begin
          idx = $urandom_range(0, live_zones.size() - 1);
          target = live_zones[idx];
          live_zones.delete(idx);
          last_freed = target;
          send_request(FUNC_FREE, target);
        end else if (pick >= 94) begin
          send_request(FUNC_FREE, last_freed);
        end else if (pick >= 86) begin
          send_request(FUNC_FREE, pick[0] ? 16'($urandom) : 16'($urandom_range(0, 16383)));
        end else begin
          send_request(FUNC_ALLOC, 16'($urandom));
          if (sb.last_outcome.status == STATUS_OK) live_zones.push_back(sb.last_outcome.zone);
        end
      end
    end

    // Drain every outstanding outcome, then watch for stray results.
    @(negedge clk);
    in_valid <= 1'b0;
    burst = 1'b0;
    while (sb.pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_outcomes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
